### sv/sws_pkg.sv
`timescale 1ns / 1ps

package sws_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_SAMPLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 3'd5;

    localparam logic [15:0] RST_START_LOW   = 16'd20000;
    localparam logic [7:0]  RST_START_HIGH  = 8'd30;
    localparam logic [7:0]  RST_RESP_SAMPLE = 8'd40;
    localparam logic [7:0]  RST_RESP_HIGH   = 8'd80;
    localparam logic [7:0]  RST_BIT_SAMPLE  = 8'd40;
    localparam logic [3:0]  RST_FRAME_BYTES = 4'd5;

    // Fixed guard delays after the high response
    localparam logic [15:0] GUARD_A_TICKS = 16'd3;
    localparam logic [15:0] GUARD_B_TICKS = 16'd25;

    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_LOW    = 10'b00_0000_0010,
        PH_HIGH   = 10'b00_0000_0100,
        PH_REL    = 10'b00_0000_1000,
        PH_RHIGH  = 10'b00_0001_0000,
        PH_GUARDA = 10'b00_0010_0000,
        PH_GUARDB = 10'b00_0100_0000,
        PH_RISE   = 10'b00_1000_0000,
        PH_SAMP   = 10'b01_0000_0000,
        PH_FALL   = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  start_high_ticks;
        logic [7:0]  response_sample_ticks;
        logic [7:0]  response_high_ticks;
        logic [7:0]  bit_sample_ticks;
        logic [3:0]  frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic       pin_drive_enable;
        logic       pin_drive_level;
        logic       busy_res;
        logic       response_valid;
        logic       response_status;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       byte_last;
    } res_t;

endpackage

### sv/sws_cfg.sv
`timescale 1ns / 1ps

module sws_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output sws_pkg::cfg_t                      cfg
);

    sws_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks       <= sws_pkg::RST_START_LOW;
            cfg_reg.start_high_ticks      <= sws_pkg::RST_START_HIGH;
            cfg_reg.response_sample_ticks <= sws_pkg::RST_RESP_SAMPLE;
            cfg_reg.response_high_ticks   <= sws_pkg::RST_RESP_HIGH;
            cfg_reg.bit_sample_ticks      <= sws_pkg::RST_BIT_SAMPLE;
            cfg_reg.frame_bytes           <= sws_pkg::RST_FRAME_BYTES;
        end else if (cfg_we) begin
            case (cfg_index)
                sws_pkg::REG_START_LOW:   cfg_reg.start_low_ticks       <= cfg_wdata;
                sws_pkg::REG_START_HIGH:  cfg_reg.start_high_ticks      <= cfg_wdata[7:0];
                sws_pkg::REG_RESP_SAMPLE: cfg_reg.response_sample_ticks <= cfg_wdata[7:0];
                sws_pkg::REG_RESP_HIGH:   cfg_reg.response_high_ticks   <= cfg_wdata[7:0];
                sws_pkg::REG_BIT_SAMPLE:  cfg_reg.bit_sample_ticks      <= cfg_wdata[7:0];
                sws_pkg::REG_FRAME_BYTES: cfg_reg.frame_bytes           <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/sws_core.sv
`timescale 1ns / 1ps

module sws_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic          pin_level,
    input  logic          start_request,
    input  sws_pkg::cfg_t cfg,
    output sws_pkg::res_t res
);

    sws_pkg::phase_t phase_reg, phase_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [3:0]  byte_count_reg, byte_count_next;

    logic [15:0] wait_inc;
    logic [4:0]  bytes_done;
    logic        rv, rs, bv, blast;
    logic [7:0]  bval;

    assign wait_inc   = wait_count_reg + 16'd1;
    assign bytes_done = {1'b0, byte_count_reg} + 5'd1;

    always_comb begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        byte_count_next = byte_count_reg;
        rv    = 1'b0;
        rs    = 1'b0;
        bv    = 1'b0;
        bval  = 8'd0;
        blast = 1'b0;
        case (phase_reg)
            sws_pkg::PH_IDLE: begin
                if (start_request) begin
                    phase_next      = sws_pkg::PH_LOW;
                    wait_count_next = 16'd1;
                    bit_index_next  = 3'd0;
                    shift_byte_next = 8'd0;
                    byte_count_next = 4'd0;
                end
            end
            sws_pkg::PH_LOW: begin
                if (wait_count_reg >= cfg.start_low_ticks) begin
                    phase_next      = sws_pkg::PH_HIGH;
                    wait_count_next = 16'd1;
                end else begin
                    wait_count_next = wait_inc;
                end
            end
            sws_pkg::PH_HIGH: begin
                if (wait_count_reg >= {8'd0, cfg.start_high_ticks}) begin
                    phase_next      = sws_pkg::PH_REL;
                    wait_count_next = 16'd0;
                end else begin
                    wait_count_next = wait_inc;
                end
            end
            sws_pkg::PH_REL: begin
                wait_count_next = wait_inc;
                if (wait_inc >= {8'd0, cfg.response_sample_ticks}) begin
                    wait_count_next = 16'd0;
                    if (!pin_level) begin
                        phase_next = sws_pkg::PH_RHIGH;
                    end else begin
                        rv         = 1'b1;
                        rs         = 1'b1;
                        phase_next = sws_pkg::PH_IDLE;
                    end
                end
            end
            sws_pkg::PH_RHIGH: begin
                wait_count_next = wait_inc;
                if (wait_inc >= {8'd0, cfg.response_high_ticks}) begin
                    wait_count_next = 16'd0;
                    if (pin_level) begin
                        phase_next = sws_pkg::PH_GUARDA;
                    end else begin
                        rv         = 1'b1;
                        rs         = 1'b1;
                        phase_next = sws_pkg::PH_IDLE;
                    end
                end
            end
            sws_pkg::PH_GUARDA: begin
                wait_count_next = wait_inc;
                if (wait_inc >= sws_pkg::GUARD_A_TICKS) begin
                    wait_count_next = 16'd0;
                    if (pin_level) begin
                        phase_next = sws_pkg::PH_GUARDB;
                    end else begin
                        rv         = 1'b1;
                        phase_next = sws_pkg::PH_RISE;
                    end
                end
            end
            sws_pkg::PH_GUARDB: begin
                wait_count_next = wait_inc;
                if (wait_inc >= sws_pkg::GUARD_B_TICKS) begin
                    wait_count_next = 16'd0;
                    rv              = 1'b1;
                    if (pin_level) begin
                        rs         = 1'b1;
                        phase_next = sws_pkg::PH_IDLE;
                    end else begin
                        phase_next = sws_pkg::PH_RISE;
                    end
                end
            end
            sws_pkg::PH_RISE: begin
                if (pin_level) begin
                    phase_next      = sws_pkg::PH_SAMP;
                    wait_count_next = 16'd0;
                end
            end
            sws_pkg::PH_SAMP: begin
                wait_count_next = wait_inc;
                if (wait_inc >= {8'd0, cfg.bit_sample_ticks}) begin
                    wait_count_next = 16'd0;
                    shift_byte_next = {shift_byte_reg[6:0], pin_level};
                    bit_index_next  = bit_index_reg + 3'd1;
                    phase_next      = sws_pkg::PH_FALL;
                end
            end
            sws_pkg::PH_FALL: begin
                if (!pin_level) begin
                    phase_next = sws_pkg::PH_RISE;
                    // A wrapped bit index means eight bits have been taken.
                    if (bit_index_reg == 3'd0) begin
                        bv              = 1'b1;
                        bval            = shift_byte_reg;
                        shift_byte_next = 8'd0;
                        if (bytes_done >= {1'b0, cfg.frame_bytes}) begin
                            blast           = 1'b1;
                            byte_count_next = 4'd0;
                            phase_next      = sws_pkg::PH_IDLE;
                        end else begin
                            byte_count_next = bytes_done[3:0];
                        end
                    end
                end
            end
            default: begin
                phase_next = sws_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= sws_pkg::PH_IDLE;
            wait_count_reg <= 16'd0;
            bit_index_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            byte_count_reg <= 4'd0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            wait_count_reg <= wait_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            byte_count_reg <= byte_count_next;
        end
    end

    always_comb begin
        res.pin_drive_enable = (phase_next == sws_pkg::PH_LOW) ||
                               (phase_next == sws_pkg::PH_HIGH);
        res.pin_drive_level  = (phase_next == sws_pkg::PH_HIGH);
        res.busy_res         = (phase_next != sws_pkg::PH_IDLE);
        res.response_valid   = rv;
        res.response_status  = rs;
        res.byte_valid       = bv;
        res.byte_value       = bval;
        res.byte_last        = blast;
    end

endmodule

### sv/single_wire_sensor_reader_unit.sv
`timescale 1ns / 1ps
// A word accepted on s_tdata is held in the input register; its result word is then
// registered into the result register on m_tdata once that register is free or emptying.
// Throughput: one word per clock cycle, sustained while m_tready stays high;
// the limit is the single state update done per tick in the core.
// Reset (aresetn low, synchronous): no word is held, the transfer state returns
// to idle and the timing registers take their default values.
module single_wire_sensor_reader_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // pin_level, start_request, zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pin_drive_enable, pin_drive_level, busy_res, response_valid, response_status,
    // byte_valid, byte_value[7:0], zero pad
    output logic [15:0]                        m_tdata,
    output logic                               m_tlast,  // byte_last
    input  logic                               cfg_we,
    input  logic [sws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sws_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    sws_pkg::cfg_t cfg;
    sws_pkg::res_t res;

    logic       in_valid_reg;
    logic       pin_reg;
    logic       start_reg;
    logic       out_valid_reg;
    sws_pkg::res_t out_reg;
    logic       advance;

    // The held word moves on whenever the result register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pin_reg   <= s_tdata[0];
            start_reg <= s_tdata[1];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    sws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sws_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .pin_level     (pin_reg),
        .start_request (start_reg),
        .cfg           (cfg),
        .res           (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.byte_value, out_reg.byte_valid,
                       out_reg.response_status, out_reg.response_valid,
                       out_reg.busy_res, out_reg.pin_drive_level,
                       out_reg.pin_drive_enable};
    assign m_tlast  = out_reg.byte_last;

endmodule

### sv/sws_checker.sv
`timescale 1ns / 1ps

module sws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A result word that is not taken stays on the port unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

    // Reset leaves no result word pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
    else $error("result word present after reset");

    // The last byte of a frame is a completed byte and ends the transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[5] && !m_tdata[2])
    else $error("frame end without a completed byte or while still busy");

    // The line is only driven high while driving and busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && m_tdata[2])
    else $error("drive level set without drive enable");

    // A failed response check ends the transfer on the same word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3] && !m_tdata[2] && !m_tlast)
    else $error("failed response while busy or without response flag");

endmodule

bind single_wire_sensor_reader_unit sws_checker u_sws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
